// File: sv/srfc_pkg.sv
// Shared constants, codes and the controller command bundle of the sensor range
// fault classifier. No dependencies; imported by every module of the block.
`default_nettype none

package srfc_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int NUM_W       = SAMPLE_BITS + 8;   // dividend width of the shared divider
  localparam int QUO_W       = 8;                 // both quotients stay below 256
  localparam int IDX_W       = 3;                 // bit index of the divider step

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX  = '1;   // 2^SAMPLE_BITS - 1
  localparam logic [6:0]             PCT_SCALE   = 7'd100;
  localparam logic [6:0]             PCT_FULL    = 7'd100;

  // Register reset values
  localparam logic [SAMPLE_BITS-1:0] HIGH_RST = SAMPLE_BITS'(920);
  localparam logic [SAMPLE_BITS-1:0] LOW_RST  = SAMPLE_BITS'(102);
  localparam logic [7:0]             DEC_RST  = 8'd20;
  localparam logic [7:0]             FS_RST   = 8'd50;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_HIGH = 2'd0;
  localparam logic [1:0] REG_LOW  = 2'd1;
  localparam logic [1:0] REG_DEC  = 2'd2;
  localparam logic [1:0] REG_FS   = 2'd3;

  // Fault codes
  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_OPEN_GND = 2'd1;
  localparam logic [1:0] FAULT_OPEN_SUP = 2'd2;

  // Seven-segment patterns, bit0 = a .. bit6 = g
  localparam logic [6:0] SEG_DIGIT0 = 7'd63;
  localparam logic [6:0] SEG_DIGIT8 = 7'd127;
  localparam logic [6:0] SEG_BLANK  = 7'd0;

  typedef struct packed {
    logic             smp_load;   // capture the accepted sample
    logic             mul_load;   // register products, start the voltage division
    logic             div_step;   // one restoring-division step
    logic             pct_load;   // keep the voltage, start the percent division
    logic             out_load;   // fill the output register
    logic [IDX_W-1:0] bit_idx;    // quotient bit decided by this step
  } srfc_cmd_t;

endpackage

`default_nettype wire

// File: sv/srfc_ctrl.sv
// Controller of the sensor range fault classifier: input handshake, decimation
// counter, sequencing of the shared divider and the output valid flag. Uses srfc_pkg.
`default_nettype none

module srfc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire logic [7:0]          dec_count,
  output srfc_pkg::srfc_cmd_t      cmd
);
  import srfc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIVV = 3'd2;
  localparam logic [2:0] S_DIVP = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic [7:0]       count_inc;
  logic             emit;
  logic             out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign count_inc = count_r + 8'd1;
  assign emit      = (count_inc >= dec_count);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    count_nxt    = count_r;
    cmd          = '0;
    cmd.bit_idx  = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.smp_load = 1'b1;
          count_nxt    = emit ? 8'd0 : count_inc;
          if (emit) begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        idx_nxt      = '1;
        state_nxt    = S_DIVV;
      end
      S_DIVV: begin
        cmd.div_step = 1'b1;
        if (idx_r == '0) begin
          // last voltage bit: hand the divider over to the percent quotient
          cmd.pct_load = 1'b1;
          idx_nxt      = '1;
          state_nxt    = S_DIVP;
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
        end
      end
      S_DIVP: begin
        cmd.div_step = 1'b1;
        if (idx_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/srfc_dp.sv
// Datapath of the sensor range fault classifier: sample register, range check,
// products, shared restoring divider and output register. Uses srfc_pkg.
`default_nettype none

module srfc_dp (
  input  wire logic                          clk,
  input  wire srfc_pkg::srfc_cmd_t           cmd,
  input  wire logic [srfc_pkg::SAMPLE_BITS-1:0] in_sample,
  input  wire logic [srfc_pkg::SAMPLE_BITS-1:0] high_thr,
  input  wire logic [srfc_pkg::SAMPLE_BITS-1:0] low_thr,
  input  wire logic [7:0]                    full_scale,
  output logic [1:0]                         out_fault_code,
  output logic [6:0]                         out_position_percent,
  output logic [7:0]                         out_volts_tenths,
  output logic [6:0]                         out_segments
);
  import srfc_pkg::*;

  logic [SAMPLE_BITS-1:0] sample_r;
  logic [1:0]             fault_r;
  logic [6:0]             seg_r;
  logic                   zero_span_r;
  logic [SAMPLE_BITS-1:0] span_r;
  logic [NUM_W-1:0]       prod_p_r;
  logic [NUM_W-1:0]       rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0] div_r;
  logic [QUO_W-1:0]       quo_r, quo_nxt;
  logic [QUO_W-1:0]       volts_r;

  logic [1:0]             fault_c;
  logic [6:0]             seg_c;
  logic [SAMPLE_BITS-1:0] diff_c;
  logic [NUM_W-1:0]       trial;
  logic                   ge;
  logic [6:0]             pct_c;

  always_comb begin
    priority if (sample_r > high_thr) begin
      fault_c = FAULT_OPEN_GND;
      seg_c   = SEG_DIGIT0;
    end else if (sample_r < low_thr) begin
      fault_c = FAULT_OPEN_SUP;
      seg_c   = SEG_DIGIT8;
    end else begin
      fault_c = FAULT_NONE;
      seg_c   = SEG_BLANK;
    end
  end

  assign diff_c = sample_r - low_thr;

  // Restoring step: the quotient always fits in QUO_W bits, so the divisor
  // shifted up by the current bit is the only trial needed.
  always_comb begin
    trial   = NUM_W'(div_r) << cmd.bit_idx;
    ge      = (rem_r >= trial);
    rem_nxt = ge ? (rem_r - trial) : rem_r;
    quo_nxt = quo_r;
    quo_nxt[cmd.bit_idx] = ge;
  end

  always_comb begin
    priority if (fault_r != FAULT_NONE) begin
      pct_c = 7'd0;
    end else if (zero_span_r) begin
      pct_c = PCT_FULL;
    end else begin
      pct_c = quo_r[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.smp_load) begin
      sample_r <= in_sample;
    end
    if (cmd.mul_load) begin
      fault_r     <= fault_c;
      seg_r       <= seg_c;
      zero_span_r <= (high_thr == low_thr);
      span_r      <= high_thr - low_thr;
      prod_p_r    <= NUM_W'(diff_c) * NUM_W'(PCT_SCALE);
    end
    priority if (cmd.mul_load) begin
      rem_r <= NUM_W'(sample_r) * NUM_W'(full_scale);
      div_r <= SAMPLE_MAX;
      quo_r <= '0;
    end else if (cmd.pct_load) begin
      volts_r <= quo_nxt;
      rem_r   <= prod_p_r;
      div_r   <= span_r;
      quo_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end else begin
      // hold the divider
    end
    if (cmd.out_load) begin
      out_fault_code       <= fault_r;
      out_position_percent <= pct_c;
      out_volts_tenths     <= volts_r;
      out_segments         <= seg_r;
    end
  end

endmodule

`default_nettype wire

// File: sv/sensor_range_fault_classifier.sv
// Top level of the sensor range fault classifier: configuration registers and the
// controller and datapath instances. Uses srfc_pkg, srfc_ctrl and srfc_dp.
//
// A sample that does not complete a decimation period is taken while the controller
// stays idle, so such samples stream at one per clock until in_stall rises. The
// sample that completes the period is classified and scaled: the multiplies are
// registered, then the shared restoring divider spends eight steps on the voltage
// (product over 1023) and eight on the percent (offset times 100 over the span),
// and a final state moves the result into the output register. The next sample is
// taken after that move, which waits only while the previous result is still held
// by out_stall. Registers are written through cfg_* at any time (cfg_ready is always
// high) but must only change while no result is pending.
`default_nettype none

module sensor_range_fault_classifier (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [srfc_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            out_fault_code,
  output logic [6:0]                            out_position_percent,
  output logic [7:0]                            out_volts_tenths,
  output logic [6:0]                            out_segments,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [srfc_pkg::SAMPLE_BITS-1:0] cfg_data
);
  import srfc_pkg::*;

  logic [SAMPLE_BITS-1:0] high_r;
  logic [SAMPLE_BITS-1:0] low_r;
  logic [7:0]             dec_r;
  logic [7:0]             fs_r;
  srfc_cmd_t              cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r <= HIGH_RST;
      low_r  <= LOW_RST;
      dec_r  <= DEC_RST;
      fs_r   <= FS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HIGH: high_r <= cfg_data;
        REG_LOW:  low_r  <= cfg_data;
        REG_DEC:  dec_r  <= cfg_data[7:0];
        REG_FS:   fs_r   <= cfg_data[7:0];
        default:  ;
      endcase
    end
  end

  srfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dec_count (dec_r),
    .cmd       (cmd)
  );

  srfc_dp u_dp (
    .clk                  (clk),
    .cmd                  (cmd),
    .in_sample            (in_sample),
    .high_thr             (high_r),
    .low_thr              (low_r),
    .full_scale           (fs_r),
    .out_fault_code       (out_fault_code),
    .out_position_percent (out_position_percent),
    .out_volts_tenths     (out_volts_tenths),
    .out_segments         (out_segments)
  );

endmodule

`default_nettype wire

// File: sv/srfc_checker.sv
// Port-level checks of the sensor range fault classifier and the bind that
// attaches them to the top level. Uses srfc_pkg.
`default_nettype none

module srfc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_fault_code,
  input wire logic [6:0] out_position_percent,
  input wire logic [7:0] out_volts_tenths,
  input wire logic [6:0] out_segments
);
  import srfc_pkg::*;

  // A stalled transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fault_code)
      && $stable(out_position_percent) && $stable(out_volts_tenths)
      && $stable(out_segments))
    else $error("result changed while stalled");

  a_fault_pct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_fault_code != FAULT_NONE) |-> out_position_percent == 7'd0)
    else $error("fault result carries a nonzero percent");

  a_seg_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_fault_code == FAULT_NONE && out_segments == SEG_BLANK)
      || (out_fault_code == FAULT_OPEN_GND && out_segments == SEG_DIGIT0)
      || (out_fault_code == FAULT_OPEN_SUP && out_segments == SEG_DIGIT8))
    else $error("display pattern does not match fault code");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_position_percent <= PCT_FULL)
    else $error("percent above full scale");

endmodule

bind sensor_range_fault_classifier srfc_checker u_srfc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_fault_code       (out_fault_code),
  .out_position_percent (out_position_percent),
  .out_volts_tenths     (out_volts_tenths),
  .out_segments         (out_segments)
);

`default_nettype wire
